// ----- rtl/basic_token_scanner_unit_macros.svh -----
// Assertion macros shared by the token scanner RTL files.
`ifndef BASIC_TOKEN_SCANNER_UNIT_MACROS_SVH
`define BASIC_TOKEN_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define BTS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("token scanner check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("token scanner check failed");

`else

`define BTS_ASSERT_IMPLY(label, ante, cons)
`define BTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/bts_pkg.sv -----
// Shared types, codes and constants of the token scanner.
`default_nettype none

package bts_pkg;

   // Text limits
   localparam int TEXT_BUFFER_SIZE = 256;
   localparam logic [7:0] TEXT_LIMIT = 8'(TEXT_BUFFER_SIZE - 2);

   // Input event kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_EOL  = 2'd1;
   localparam logic [1:0] KIND_EOF  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   // Token kinds
   localparam logic [3:0] TK_INT     = 4'd0;
   localparam logic [3:0] TK_DEC     = 4'd1;
   localparam logic [3:0] TK_NAMECH  = 4'd2;
   localparam logic [3:0] TK_STRCH   = 4'd3;
   localparam logic [3:0] TK_LPAREN  = 4'd4;
   localparam logic [3:0] TK_RPAREN  = 4'd5;
   localparam logic [3:0] TK_PLUS    = 4'd6;
   localparam logic [3:0] TK_MINUS   = 4'd7;
   localparam logic [3:0] TK_STAR    = 4'd8;
   localparam logic [3:0] TK_SLASH   = 4'd9;
   localparam logic [3:0] TK_EQUAL   = 4'd10;
   localparam logic [3:0] TK_EOL     = 4'd11;
   localparam logic [3:0] TK_EOF     = 4'd12;
   localparam logic [3:0] TK_ERR     = 4'd13;
   localparam logic [3:0] TK_STREND  = 4'd14;
   localparam logic [3:0] TK_NAMEEND = 4'd15;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NUMBER     = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
   localparam logic [2:0] ERR_UNTERM_STR = 3'd3;
   localparam logic [2:0] ERR_SYNTAX     = 3'd4;

   // Character codes
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_LPAREN = 8'd40;
   localparam logic [7:0] CH_RPAREN = 8'd41;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_PLUS   = 8'd43;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CH_DOT    = 8'd46;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_EQUAL  = 8'd61;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;

   // One result transaction
   typedef struct packed {
      logic [3:0]  token_kind;
      logic [31:0] mantissa;
      logic [7:0]  fraction_digits;
      logic [7:0]  text_char;
      logic [2:0]  error_code;
   } result_type;

   // Results produced by one input transaction, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } batch_type;

   function automatic result_type make_result(input logic [3:0] tk,
                                              input logic [31:0] mant,
                                              input logic [7:0] frac,
                                              input logic [7:0] tc,
                                              input logic [2:0] err);
      result_type r;
      r.token_kind      = tk;
      r.mantissa        = mant;
      r.fraction_digits = frac;
      r.text_char       = tc;
      r.error_code      = err;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bts_channels.sv -----
// Valid/ready channel interfaces for scanner requests and responses.
`default_nettype none

interface bts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] ch;

   modport source(output valid, output kind, output ch, input ready);
   modport sink(input valid, input kind, input ch, output ready);
endinterface

interface bts_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] mantissa;
   logic [7:0]  fraction_digits;
   logic [7:0]  text_char;
   logic [2:0]  error_code;

   modport source(output valid, output token_kind, output mantissa,
                  output fraction_digits, output text_char, output error_code,
                  input ready);
   modport sink(input valid, input token_kind, input mantissa,
                input fraction_digits, input text_char, input error_code,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/bts_scan_core.sv -----
// Scanner state machine: mode, number accumulator, text length, result decode.
`default_nettype none
`include "basic_token_scanner_unit_macros.svh"

module bts_scan_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [1:0]        kind,
   input  wire logic [7:0]        ch,
   output bts_pkg::batch_type     batch
);

   typedef enum logic [2:0] {
      M_IDLE,
      M_INT,
      M_FRAC,
      M_NAME,
      M_STR
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  frac_ff, frac_in;
   logic [7:0]  len_ff, len_in;

   // Character classes
   logic is_char, is_digit, is_alpha, is_space;
   assign is_char  = (kind == bts_pkg::KIND_CHAR);
   assign is_digit = (ch >= bts_pkg::CH_ZERO) && (ch <= bts_pkg::CH_NINE);
   assign is_alpha = ((ch >= bts_pkg::CH_UPPER_A) && (ch <= bts_pkg::CH_UPPER_Z)) ||
                     ((ch >= bts_pkg::CH_LOWER_A) && (ch <= bts_pkg::CH_LOWER_Z));
   assign is_space = (ch == bts_pkg::CH_SPACE) ||
                     ((ch >= bts_pkg::CH_TAB) && (ch <= bts_pkg::CH_CR));

   // acc * 10 + digit, saturating at all ones
   logic [35:0] acc_prod;
   logic [31:0] acc_sat;
   assign acc_prod = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {32'd0, ch[3:0]};
   assign acc_sat  = (acc_prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_prod[31:0];

   // What an item does when it meets the scanner in idle
   logic                 idle_emit;
   bts_pkg::result_type  idle_res;
   logic                 idle_num, idle_name, idle_str;
   always_comb begin
      idle_emit = 1'b0;
      idle_res  = '0;
      idle_num  = 1'b0;
      idle_name = 1'b0;
      idle_str  = 1'b0;
      if (kind == bts_pkg::KIND_EOL) begin
         idle_emit = 1'b1;
         idle_res  = bts_pkg::make_result(bts_pkg::TK_EOL, '0, '0, '0, bts_pkg::ERR_NONE);
      end else if (kind == bts_pkg::KIND_EOF) begin
         idle_emit = 1'b1;
         idle_res  = bts_pkg::make_result(bts_pkg::TK_EOF, '0, '0, '0, bts_pkg::ERR_NONE);
      end else if (is_char && !is_space) begin
         if (is_digit) begin
            idle_num = 1'b1;
         end else if (is_alpha) begin
            idle_name = 1'b1;
            idle_emit = 1'b1;
            idle_res  = bts_pkg::make_result(bts_pkg::TK_NAMECH, '0, '0, ch,
                                             bts_pkg::ERR_NONE);
         end else if (ch == bts_pkg::CH_QUOTE) begin
            idle_str = 1'b1;
         end else begin
            idle_emit = 1'b1;
            idle_res  = bts_pkg::make_result(bts_pkg::TK_ERR, '0, '0, '0,
                                             bts_pkg::ERR_SYNTAX);
            case (ch)
               bts_pkg::CH_LPAREN: idle_res.token_kind = bts_pkg::TK_LPAREN;
               bts_pkg::CH_RPAREN: idle_res.token_kind = bts_pkg::TK_RPAREN;
               bts_pkg::CH_PLUS:   idle_res.token_kind = bts_pkg::TK_PLUS;
               bts_pkg::CH_MINUS:  idle_res.token_kind = bts_pkg::TK_MINUS;
               bts_pkg::CH_STAR:   idle_res.token_kind = bts_pkg::TK_STAR;
               bts_pkg::CH_SLASH:  idle_res.token_kind = bts_pkg::TK_SLASH;
               bts_pkg::CH_EQUAL:  idle_res.token_kind = bts_pkg::TK_EQUAL;
               default:            idle_res.token_kind = bts_pkg::TK_ERR;
            endcase
            if (idle_res.token_kind != bts_pkg::TK_ERR) begin
               idle_res.error_code = bts_pkg::ERR_NONE;
            end
         end
      end
   end

   // Mode-specific handling; items that end a token fall through to idle
   logic                pre_valid, use_idle;
   bts_pkg::result_type pre;
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      len_in    = len_ff;
      pre_valid = 1'b0;
      use_idle  = 1'b0;
      pre       = '0;
      batch     = '0;
      if (kind != bts_pkg::KIND_NONE) begin
         case (mode_ff)
            M_INT: begin
               if (is_char && is_digit) begin
                  acc_in = acc_sat;
               end else if (is_char && ch == bts_pkg::CH_DOT) begin
                  mode_in = M_FRAC;
                  frac_in = '0;
               end else begin
                  pre_valid = 1'b1;
                  use_idle  = 1'b1;
                  pre = bts_pkg::make_result(bts_pkg::TK_INT, acc_ff, '0, '0,
                                             bts_pkg::ERR_NONE);
               end
            end
            M_FRAC: begin
               if (is_char && is_digit) begin
                  acc_in = acc_sat;
                  if (frac_ff != 8'hFF) begin
                     frac_in = frac_ff + 8'd1;
                  end
               end else if (is_char && ch == bts_pkg::CH_DOT) begin
                  mode_in   = M_IDLE;
                  pre_valid = 1'b1;
                  pre = bts_pkg::make_result(bts_pkg::TK_ERR, '0, '0, '0,
                                             bts_pkg::ERR_NUMBER);
               end else begin
                  pre_valid = 1'b1;
                  use_idle  = 1'b1;
                  pre = bts_pkg::make_result(bts_pkg::TK_DEC, acc_ff, frac_ff, '0,
                                             bts_pkg::ERR_NONE);
               end
            end
            M_NAME: begin
               pre_valid = 1'b1;
               if (is_char && (is_alpha || is_digit)) begin
                  if (len_ff >= bts_pkg::TEXT_LIMIT) begin
                     mode_in = M_IDLE;
                     pre = bts_pkg::make_result(bts_pkg::TK_ERR, '0, '0, '0,
                                                bts_pkg::ERR_TOO_LONG);
                  end else begin
                     len_in = len_ff + 8'd1;
                     pre = bts_pkg::make_result(bts_pkg::TK_NAMECH, '0, '0, ch,
                                                bts_pkg::ERR_NONE);
                  end
               end else begin
                  use_idle = 1'b1;
                  pre = bts_pkg::make_result(bts_pkg::TK_NAMEEND, '0, '0, '0,
                                             bts_pkg::ERR_NONE);
               end
            end
            M_STR: begin
               pre_valid = 1'b1;
               if (!is_char) begin
                  mode_in = M_IDLE;
                  pre = bts_pkg::make_result(bts_pkg::TK_ERR, '0, '0, '0,
                                             bts_pkg::ERR_UNTERM_STR);
               end else if (ch == bts_pkg::CH_QUOTE) begin
                  mode_in = M_IDLE;
                  pre = bts_pkg::make_result(bts_pkg::TK_STREND, '0, '0, '0,
                                             bts_pkg::ERR_NONE);
               end else if (len_ff >= bts_pkg::TEXT_LIMIT) begin
                  mode_in = M_IDLE;
                  pre = bts_pkg::make_result(bts_pkg::TK_ERR, '0, '0, '0,
                                             bts_pkg::ERR_TOO_LONG);
               end else begin
                  len_in = len_ff + 8'd1;
                  pre = bts_pkg::make_result(bts_pkg::TK_STRCH, '0, '0, ch,
                                             bts_pkg::ERR_NONE);
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase

         // Apply the idle handling and order the results
         if (use_idle) begin
            mode_in = M_IDLE;
            if (idle_num) begin
               mode_in = M_INT;
               acc_in  = {28'd0, ch[3:0]};
               frac_in = '0;
            end
            if (idle_name) begin
               mode_in = M_NAME;
               len_in  = 8'd1;
            end
            if (idle_str) begin
               mode_in = M_STR;
               len_in  = '0;
            end
            batch.count = {1'b0, pre_valid} + {1'b0, idle_emit};
            if (pre_valid) begin
               batch.first  = pre;
               batch.second = idle_res;
            end else begin
               batch.first  = idle_res;
            end
         end else begin
            batch.count = {1'b0, pre_valid};
            batch.first = pre;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= '0;
         frac_ff <= '0;
         len_ff  <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         len_ff  <= len_in;
      end
   end

   // Checks
   `BTS_ASSERT_IMPLY(a_text_len_bound, (mode_ff == M_NAME || mode_ff == M_STR), (len_ff <= bts_pkg::TEXT_LIMIT))
   `BTS_ASSERT_NEXT(a_digit_starts_int, (step && mode_ff == M_IDLE && is_char && is_digit), (mode_ff == M_INT))

endmodule

`default_nettype wire

// ----- rtl/basic_token_scanner_unit.sv -----
// Top level of the token scanner: input register, scan core, result queue.
//
//   channel   | dir | transaction payload
//   ----------+-----+---------------------------------------------------------
//   req_chan  | in  | kind, ch: one character, end-of-line or end-of-file
//   rsp_chan  | out | token_kind, mantissa, fraction_digits, text_char,
//             |     | error_code: one token, text character or error
//
// One request transaction enters per cycle while req_chan.ready is high. It
// is held in the input register and decoded from there, and its zero, one
// or two responses land in a three-entry queue. An item that yields two
// responses (a number or name closed by a token) takes two queue entries.
// The queue holds the decode stage while it has two or more entries, which
// backs up into req_chan.ready. Synchronous reset returns the scanner to idle
// and empties the queue.
`default_nettype none
`include "basic_token_scanner_unit_macros.svh"

module basic_token_scanner_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   bts_req_if.sink     req_chan,
   bts_rsp_if.source   rsp_chan
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_kind_ff;
   logic [7:0] in_ch_ff;

   // Result queue
   bts_pkg::result_type q_ff [3];
   logic [1:0] head_ff, head_in;
   logic [1:0] count_ff, count_in;

   logic                advance;
   logic                req_take;
   logic                pop;
   logic [1:0]          push_count;
   logic [1:0]          tail0, tail1;
   bts_pkg::batch_type  batch;

   function automatic logic [1:0] wrap3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

   // Handshakes
   assign advance        = in_valid_ff && (count_ff <= 2'd1);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (count_ff != 2'd0);
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   // Decode
   bts_scan_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .kind  (in_kind_ff),
      .ch    (in_ch_ff),
      .batch (batch)
   );

   // Queue pointers
   assign push_count  = advance ? batch.count : 2'd0;
   assign tail0       = wrap3(head_ff, count_ff);
   assign tail1       = wrap3(tail0, 2'd1);
   assign head_in     = pop ? wrap3(head_ff, 2'd1) : head_ff;
   assign count_in    = count_ff + push_count - {1'b0, pop};
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // Response payload from the queue head
   assign rsp_chan.token_kind      = q_ff[head_ff].token_kind;
   assign rsp_chan.mantissa        = q_ff[head_ff].mantissa;
   assign rsp_chan.fraction_digits = q_ff[head_ff].fraction_digits;
   assign rsp_chan.text_char       = q_ff[head_ff].text_char;
   assign rsp_chan.error_code      = q_ff[head_ff].error_code;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         head_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_chan.kind;
         in_ch_ff   <= req_chan.ch;
      end
      if (push_count != 2'd0) begin
         q_ff[tail0] <= batch.first;
      end
      if (push_count == 2'd2) begin
         q_ff[tail1] <= batch.second;
      end
   end

   // Checks
   `BTS_ASSERT_IMPLY(a_ignored_kind_silent, (advance && in_kind_ff == bts_pkg::KIND_NONE), (push_count == 2'd0))
   `BTS_ASSERT_NEXT(a_pop_drains, (pop && push_count == 2'd0), (count_ff == $past(count_ff) - 2'd1))
   `BTS_ASSERT_IMPLY(a_two_need_room, (push_count == 2'd2), (count_ff <= 2'd1))

endmodule

`default_nettype wire
